>>> hdl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the symbol section sort / relocate block.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Default store depth
  localparam int MAX_SYMBOLS_DEF = 64;

  // Section codes
  localparam logic [1:0] SEC_NONE   = 2'd0;
  localparam logic [1:0] SEC_DATA   = 2'd1;
  localparam logic [1:0] SEC_RODATA = 2'd2;
  localparam logic [1:0] SEC_BSS    = 2'd3;

  // Input request payload
  typedef struct packed {
    logic [31:0] sym_addr;
    logic [1:0]  sym_section;
    logic        is_last;
  } sym_t;

  // Result payload
  typedef struct packed {
    logic [31:0] out_addr;
    logic [1:0]  out_section;
    logic        out_last;
    logic        error;
  } res_t;

  // One store entry
  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  sect;
  } entry_t;

  // Configuration register values
  typedef struct packed {
    logic [31:0] text_size;
    logic [31:0] data_size;
    logic [31:0] rodata_size;
  } cfg_t;

  // Sequencer to selector controls
  typedef struct packed {
    logic clear_taken;
    logic scan_start;
    logic mark;
  } sel_ctl_t;

  // Selector status back to the sequencer
  typedef struct packed {
    logic   found;
    entry_t best;
  } sel_stat_t;

endpackage

>>> hdl/ssr_cfg.sv
// ----------------------------------------------------------------------------
// ssr_cfg
// APB register file: text, data and rodata section sizes.
// ----------------------------------------------------------------------------
module ssr_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ssr_pkg::cfg_t cfg
);
  import ssr_pkg::*;

  localparam logic [1:0] REG_TEXT   = 2'd0;
  localparam logic [1:0] REG_DATA   = 2'd1;
  localparam logic [1:0] REG_RODATA = 2'd2;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TEXT:   cfg.text_size   <= pwdata;
        REG_DATA:   cfg.data_size   <= pwdata;
        REG_RODATA: cfg.rodata_size <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_TEXT:   prdata = cfg.text_size;
      REG_DATA:   prdata = cfg.data_size;
      REG_RODATA: prdata = cfg.rodata_size;
      default:    prdata = '0;
    endcase
  end

endmodule

>>> hdl/ssr_store.sv
// ----------------------------------------------------------------------------
// ssr_store
// Symbol store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssr_store #(
  parameter int MAX_SYMBOLS = ssr_pkg::MAX_SYMBOLS_DEF,
  parameter int IDX_W       = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  ssr_pkg::entry_t  wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output ssr_pkg::entry_t  rd_data
);
  import ssr_pkg::*;

  entry_t mem [MAX_SYMBOLS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

>>> hdl/ssr_select.sv
// ----------------------------------------------------------------------------
// ssr_select
// Running minimum over the streamed store entries, keyed by section then
// address; earliest index wins ties. Holds the taken marks.
// ----------------------------------------------------------------------------
module ssr_select #(
  parameter int MAX_SYMBOLS = ssr_pkg::MAX_SYMBOLS_DEF,
  parameter int IDX_W       = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  ssr_pkg::sel_ctl_t  ctl,
  input  logic               rd_valid,
  input  logic [IDX_W-1:0]   rd_idx,
  input  ssr_pkg::entry_t    rd_data,
  output ssr_pkg::sel_stat_t stat
);
  import ssr_pkg::*;

  logic [MAX_SYMBOLS-1:0] taken;
  logic [IDX_W-1:0]       best_idx;
  logic                   better;

  // Candidate beats the current best only when strictly smaller
  assign better = rd_valid && !taken[rd_idx] &&
                  (!stat.found || ({rd_data.sect, rd_data.addr} <
                                   {stat.best.sect, stat.best.addr}));

  // Taken marks
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_taken) begin
      taken <= '0;
    end else if (ctl.mark) begin
      taken[best_idx] <= 1'b1;
    end
  end

  // Found flag and best entry payload
  always_ff @(posedge clk) begin
    if (rst || ctl.scan_start) begin
      stat.found <= 1'b0;
    end else if (better) begin
      stat.found <= 1'b1;
    end
    if (better) begin
      stat.best <= rd_data;
      best_idx  <= rd_idx;
    end
  end

endmodule

>>> hdl/symbol_section_sort_relocate_top.sv
// ----------------------------------------------------------------------------
// symbol_section_sort_relocate_top
// Collects a batch of symbols, then emits them grouped data, rodata, bss,
// ascending by address, each relocated by a running section offset.
// ----------------------------------------------------------------------------
// Loading: one symbol request per cycle; the batch's last request starts output.
// Output: each of the n results takes a full pass over the store through its
//   single read port. A bad batch gives a single error result instead.
// Reset (rst, synchronous): clears counts, the bad flag, taken marks and the
//   size registers; store contents stay undefined until written.
module symbol_section_sort_relocate_top #(
  parameter int MAX_SYMBOLS = ssr_pkg::MAX_SYMBOLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          sym_valid,
  output logic          sym_ready,
  input  ssr_pkg::sym_t sym,
  output logic          res_valid,
  input  logic          res_ready,
  output ssr_pkg::res_t res
);
  import ssr_pkg::*;

  localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SYMBOLS);

  typedef enum logic [2:0] {
    ST_LOAD, ST_ERR, ST_BASE, ST_OFF2, ST_OFF3, ST_SCAN, ST_PICK
  } state_t;

  state_t           state;
  cfg_t             cfg;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] iss;
  logic [CNT_W-1:0] emit;
  logic             bad;
  logic             bad_now;
  logic             sym_fire;
  logic             full;
  logic             rd_en;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx_q;
  logic [31:0]      off1;
  logic [31:0]      off2;
  logic [31:0]      off3;
  logic [31:0]      sel_off;
  logic             out_free;
  logic             pick_fire;
  logic             pick_last;
  entry_t           wr_data;
  entry_t           rd_data;
  sel_ctl_t         sel_ctl;
  sel_stat_t        sel_stat;

  // Configuration registers
  ssr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Load and scan never overlap: the sequencer interlocks write and read
  assign sym_ready = (state == ST_LOAD);
  assign sym_fire  = sym_valid && sym_ready;
  assign full      = (count == MAX_CNT);
  assign bad_now   = bad || full || (sym.sym_section == SEC_NONE);
  assign wr_data   = '{addr: sym.sym_addr, sect: sym.sym_section};
  assign rd_en     = (state == ST_SCAN) && (iss != count);

  ssr_store #(.MAX_SYMBOLS(MAX_SYMBOLS), .IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .wr_en   (sym_fire && !full),
    .wr_idx  (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (iss[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Selector control
  assign out_free  = !res_valid || res_ready;
  assign pick_fire = (state == ST_PICK) && out_free;
  assign pick_last = ((emit + CNT_W'(1)) == count);

  assign sel_ctl.clear_taken = (state == ST_BASE);
  assign sel_ctl.scan_start  = (state == ST_OFF3) || (pick_fire && !pick_last);
  assign sel_ctl.mark        = pick_fire;

  ssr_select #(.MAX_SYMBOLS(MAX_SYMBOLS), .IDX_W(IDX_W)) u_select (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sel_ctl),
    .rd_valid (rd_pend),
    .rd_idx   (rd_idx_q),
    .rd_data  (rd_data),
    .stat     (sel_stat)
  );

  // Offset of the winner's group
  always_comb begin
    case (sel_stat.best.sect)
      SEC_DATA:   sel_off = off1;
      SEC_RODATA: sel_off = off2;
      default:    sel_off = off3;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      iss       <= '0;
      emit      <= '0;
      bad       <= 1'b0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_pend  <= rd_en;
      rd_idx_q <= iss[IDX_W-1:0];
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (sym_fire) begin
            bad <= bad_now;
            if (!full) begin
              count <= count + CNT_W'(1);
            end
            if (sym.is_last) begin
              state <= bad_now ? ST_ERR : ST_BASE;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            res       <= '{out_addr: '0, out_section: SEC_NONE, out_last: 1'b1,
                           error: 1'b1};
            res_valid <= 1'b1;
            count     <= '0;
            bad       <= 1'b0;
            state     <= ST_LOAD;
          end
        end
        ST_BASE: begin
          off1  <= cfg.text_size + ((32'(count) + 32'd1) << 2);
          emit  <= '0;
          state <= ST_OFF2;
        end
        ST_OFF2: begin
          off2  <= off1 + cfg.data_size;
          state <= ST_OFF3;
        end
        ST_OFF3: begin
          off3  <= off2 + cfg.rodata_size;
          iss   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_en) begin
            iss <= iss + CNT_W'(1);
          end else if (!rd_pend) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (out_free) begin
            res       <= '{out_addr: sel_stat.best.addr + sel_off,
                           out_section: sel_stat.best.sect,
                           out_last: pick_last, error: 1'b0};
            res_valid <= 1'b1;
            if (pick_last) begin
              count <= '0;
              emit  <= '0;
              bad   <= 1'b0;
              state <= ST_LOAD;
            end else begin
              emit  <= emit + CNT_W'(1);
              iss   <= '0;
              state <= ST_SCAN;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // An error result is always the sole, final result with zero fields
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error |-> res.out_last && (res.out_addr == 32'd0))
    else $error("error result not final or not zero");

  // Every pick follows a scan that found an untaken entry
  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_PICK |-> sel_stat.found)
    else $error("pick without a selected entry");

  // No more results than stored symbols
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PICK |-> emit < count)
    else $error("emitted more results than symbols");

  // Store is never read while symbols are loading
  a_no_read_load: assert property (@(posedge clk) disable iff (rst)
    sym_fire |-> !rd_pend)
    else $error("store read overlaps loading");

endmodule

>>> tb/sv/ssr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_tb_pkg
// Register map of the configuration port, shared by the stimulus and the
// scoreboard of the symbol sort / relocate testbench.
// ----------------------------------------------------------------------------
package ssr_tb_pkg;

  // Register index; byte address is index * 4
  typedef enum logic [1:0] {
    REG_TEXT_SIZE   = 2'd0,
    REG_DATA_SIZE   = 2'd1,
    REG_RODATA_SIZE = 2'd2
  } cfg_reg_e;

endpackage

>>> tb/sv/ssr_reloc_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_reloc_scoreboard
// Watches the config port and both request channels, keeps its own copy of
// the symbol store and section sizes, builds the expected results (sorted,
// relocated, or one error) per finished batch and checks results in order.
// ----------------------------------------------------------------------------
module ssr_reloc_scoreboard (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          sym_valid,
  input  logic          sym_ready,
  input  ssr_pkg::sym_t sym,
  input  logic          res_valid,
  input  logic          res_ready,
  input  ssr_pkg::res_t res,
  output int            fail_cnt,
  output int            pending,
  output int            relocs_checked,
  output int            errors_checked
);
  import ssr_pkg::*;
  import ssr_tb_pkg::*;

  localparam int DEPTH      = MAX_SYMBOLS_DEF;
  localparam int REPORT_MAX = 10;

  // Shadow of the block's section sizes and symbol store
  logic [31:0] text_sz;
  logic [31:0] data_sz;
  logic [31:0] rodata_sz;
  logic [31:0] addr_mem [DEPTH];
  logic [1:0]  sect_mem [DEPTH];
  int          held;
  bit          spoiled;

  // Relocated symbols still owed by the block, oldest first
  res_t relocs_q [$];

  initial begin
    fail_cnt       = 0;
    pending        = 0;
    relocs_checked = 0;
    errors_checked = 0;
  end

  // Sort the held batch by group then address (stable), add running offsets
  task automatic emit_batch();
    logic [1:0]  order [3] = '{SEC_DATA, SEC_RODATA, SEC_BSS};
    bit          used [DEPTH];
    logic [31:0] base;
    int          pick;
    res_t        r;
    base = text_sz + 32'(4 * (held + 1));
    for (int g = 0; g < 3; g++) begin
      do begin
        pick = -1;
        for (int j = 0; j < held; j++) begin
          if (sect_mem[j] == order[g] && !used[j] &&
              (pick < 0 || addr_mem[j] < addr_mem[pick]))
            pick = j;
        end
        if (pick >= 0) begin
          used[pick]    = 1'b1;
          r.out_addr    = addr_mem[pick] + base;
          r.out_section = order[g];
          r.out_last    = 1'b0;
          r.error       = 1'b0;
          relocs_q.push_back(r);
        end
      end while (pick >= 0);
      if (order[g] == SEC_DATA) base += data_sz;
      else if (order[g] == SEC_RODATA) base += rodata_sz;
    end
    // flag the final entry of the batch
    r = relocs_q.pop_back();
    r.out_last = 1'b1;
    relocs_q.push_back(r);
  endtask

  // Store one symbol; the batch's last one produces the expected list
  task automatic take_symbol(input sym_t s);
    res_t r;
    if (s.sym_section == SEC_NONE) spoiled = 1'b1;
    if (held >= DEPTH) begin
      spoiled = 1'b1;
    end else begin
      addr_mem[held] = s.sym_addr;
      sect_mem[held] = s.sym_section;
      held++;
    end
    if (s.is_last) begin
      if (spoiled) begin
        r = '{out_addr: '0, out_section: SEC_NONE, out_last: 1'b1, error: 1'b1};
        relocs_q.push_back(r);
      end else begin
        emit_batch();
      end
      held    = 0;
      spoiled = 1'b0;
    end
  endtask

  // Compare one result with the oldest expectation
  task automatic check_result(input res_t got);
    res_t want;
    if (relocs_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX)
        $display("%0t: result with nothing expected: addr %h sect %0d last %b err %b",
                 $realtime, got.out_addr, got.out_section, got.out_last, got.error);
      return;
    end
    want = relocs_q.pop_front();
    if (want.error) errors_checked++;
    else relocs_checked++;
    if (got.out_addr !== want.out_addr || got.out_section !== want.out_section ||
        got.out_last !== want.out_last || got.error !== want.error) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX)
        $display("%0t: mismatch exp addr %h sect %0d last %b err %b / got %h %0d %b %b",
                 $realtime, want.out_addr, want.out_section, want.out_last, want.error,
                 got.out_addr, got.out_section, got.out_last, got.error);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      text_sz   = '0;
      data_sz   = '0;
      rodata_sz = '0;
      held      = 0;
      spoiled   = 1'b0;
      relocs_q.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[3:2]))
          REG_TEXT_SIZE:   text_sz   = pwdata;
          REG_DATA_SIZE:   data_sz   = pwdata;
          REG_RODATA_SIZE: rodata_sz = pwdata;
          default: ;
        endcase
      end
      if (res_valid && res_ready) check_result(res);
      if (sym_valid && sym_ready) take_symbol(sym);
    end
    pending <= relocs_q.size();
  end

endmodule

>>> tb/sv/symbol_section_sort_relocate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_section_sort_relocate_top_tb
// Drives symbol batches (good, with invalid sections, full and overflowing
// store) under four section-size settings and four idle/stall mixes, with one
// long result hold-off; the scoreboard checks every relocated result.
// ----------------------------------------------------------------------------
module symbol_section_sort_relocate_top_tb;
  import ssr_pkg::*;
  import ssr_tb_pkg::*;

  localparam int DEPTH       = MAX_SYMBOLS_DEF;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;
  localparam int TAIL        = 64;

  logic        clk;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        sym_valid = 1'b0;
  logic        sym_ready;
  sym_t        sym       = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;

  int fail_cnt;
  int pending;
  int relocs_checked;
  int errors_checked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_items     = 0;
  int batches        = 0;

  symbol_section_sort_relocate_top uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .sym_valid, .sym_ready, .sym, .res_valid, .res_ready, .res
  );

  ssr_reloc_scoreboard scoreboard (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .sym_valid, .sym_ready, .sym, .res_valid, .res_ready, .res,
    .fail_cnt, .pending, .relocs_checked, .errors_checked
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on the first batch end
  int hold_left  = 0;
  bit hold_armed = 1'b1;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!rst && hold_armed && sym_valid && sym_ready && sym.is_last) begin
      res_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any request moving
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (sym_valid && sym_ready) || (res_valid && res_ready) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("FAIL symbol_section_sort_relocate_top");
      $finish;
    end
  end

  // Config write: setup cycle, access cycle, then release
  task automatic cfg_write(input cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(input logic [31:0] t, input logic [31:0] d, input logic [31:0] ro);
    cfg_write(REG_TEXT_SIZE, t);
    cfg_write(REG_DATA_SIZE, d);
    cfg_write(REG_RODATA_SIZE, ro);
  endtask

  // Offer one symbol request and hold it until taken
  task automatic send_sym(input logic [31:0] a, input logic [1:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_valid <= 1'b0;
      @(posedge clk);
    end
    sym_valid <= 1'b1;
    sym       <= '{sym_addr: a, sym_section: s, is_last: l};
    @(posedge clk);
    while (!sym_ready) @(posedge clk);
    sent_items++;
    if (l) batches++;
  endtask

  // Mix of edge addresses, tiny values (ties) and full-range values
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // One batch of n symbols; a spoiled batch carries one invalid section
  task automatic send_batch(input int n, input bit spoil);
    int         bad_at;
    logic [1:0] s;
    bad_at = spoil ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      s = (i == bad_at) ? SEC_NONE : 2'($urandom_range(SEC_DATA, SEC_BSS));
      send_sym(pick_addr(), s, i == n - 1);
    end
  endtask

  task automatic random_batches(input int quota);
    int start;
    int pick;
    start = sent_items;
    while (sent_items - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 12)      send_batch($urandom_range(1, 6), 1'b1);
      else if (pick < 25) send_batch($urandom_range(9, 16), 1'b0);
      else                send_batch($urandom_range(1, 8), 1'b0);
    end
  endtask

  // Stop offering, wait for every owed result, then let the block settle
  task automatic drain();
    sym_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes (all zero), no idling; directed cases first
    send_sym(32'h0000_0000, SEC_DATA, 1'b1);
    // all groups, ties, address extremes
    send_sym(32'h0000_0005, SEC_BSS, 1'b0);
    send_sym(32'hFFFF_FFFF, SEC_DATA, 1'b0);
    send_sym(32'h0000_0003, SEC_RODATA, 1'b0);
    send_sym(32'h0000_0000, SEC_DATA, 1'b0);
    send_sym(32'h0000_0003, SEC_RODATA, 1'b0);
    send_sym(32'h0000_0005, SEC_BSS, 1'b0);
    send_sym(32'hFFFF_FFFF, SEC_RODATA, 1'b1);
    // invalid section mid-batch
    send_sym(32'h0000_0010, SEC_DATA, 1'b0);
    send_sym(32'h0000_0020, SEC_NONE, 1'b0);
    send_sym(32'h0000_0030, SEC_BSS, 1'b1);
    // invalid section on the last symbol alone
    send_sym(32'h0000_0007, SEC_NONE, 1'b1);
    // single bss at all ones; rodata only, reversed
    send_sym(32'hFFFF_FFFF, SEC_BSS, 1'b1);
    send_sym(32'h0000_0002, SEC_RODATA, 1'b0);
    send_sym(32'h0000_0001, SEC_RODATA, 1'b1);
    random_batches(40);
    drain();

    // All-ones sizes, sender idling
    set_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_idle_pct  = 81;
    recv_stall_pct = 0;
    random_batches(40);
    drain();

    // Random sizes, receiver stalling; full store
    set_sizes($urandom, $urandom, $urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    send_batch(DEPTH, 1'b0);
    random_batches(10);
    drain();

    // Max text, zero data, light idling on both sides; store overflow
    set_sizes(32'hFFFF_FFFF, 32'h0000_0000, $urandom);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    send_batch(DEPTH + 1, 1'b0);
    random_batches(10);
    drain();
    repeat (TAIL) @(posedge clk);

    $display("Run covered %0d symbol requests in %0d batches over four size settings.",
             sent_items, batches);
    $display("Checked %0d relocated symbols and %0d rejected batches.",
             relocs_checked, errors_checked);
    if (fail_cnt == 0 && pending == 0)
      $display("PASS symbol_section_sort_relocate_top");
    else
      $display("FAIL symbol_section_sort_relocate_top");
    $finish;
  end

endmodule

>>> sim.f
hdl/ssr_pkg.sv
hdl/ssr_cfg.sv
hdl/ssr_store.sv
hdl/ssr_select.sv
hdl/symbol_section_sort_relocate_top.sv
tb/sv/ssr_tb_pkg.sv
tb/sv/ssr_reloc_scoreboard.sv
tb/sv/symbol_section_sort_relocate_top_tb.sv
